// ===== rtl/bm25ts_pkg.sv =====
// Shared types, codes and sizing constants for the BM25 term scorer.
package bm25ts_pkg;

  // Fraction bits of every score (Q16.16 by default)
  localparam int FRAC_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_K  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_N_DOCS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_LEN  = 3'd4;

  localparam logic [15:0] SAT_K_RST  = 16'd4915;
  localparam logic [16:0] LEN_B_RST  = 17'd49152;
  localparam logic [16:0] LEN_B_ONE  = 17'd65536;

  // Request opcodes
  localparam logic OP_TERM_WEIGHT = 1'b0;
  localparam logic OP_DOC_SCORE   = 1'b1;

  typedef enum logic [1:0] {
    METRIC_CLASSIC,
    METRIC_TF_IDF,
    METRIC_LOG_TF_IDF,
    METRIC_SPARSE
  } metric_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_UNDEF
  } status_t;

  // Which unit supplies the final result
  typedef enum logic [2:0] {
    SRC_DIRECT,
    SRC_LN_CLASSIC,
    SRC_LN_TF,
    SRC_LN_SCORE,
    SRC_BM25
  } src_t;

  localparam logic [31:0] SCORE_MAX = 32'hFFFF_FFFF;

  // Log unit
  localparam int LOG_W      = 35;
  localparam int LOG_LEN_W  = 6;
  localparam int LOG_FRAC   = 28;
  localparam int LOG_MANT_W = 29;
  localparam int LOG_RES_W  = FRAC_BITS + 7;
  localparam logic [28:0] LN2_Q29 = 29'd372130559;
  localparam int LOG_LAT    = 3 + LOG_MANT_W + LOG_FRAC + 3;

  // Classic score unit
  localparam int RATIO_BITS = 46;
  localparam int QUOT_BITS  = 32;
  localparam int NUM_W      = 49;
  localparam int BM25_LAT   = 2 + RATIO_BITS + 5 + QUOT_BITS;
  localparam int LOG_PAD    = BM25_LAT - LOG_LAT;

  typedef struct packed {
    logic clamp;
    logic undef;
  } bm25_flags_t;

  typedef struct packed {
    src_t        src;
    logic [31:0] score;
    status_t     status;
  } side_t;

endpackage

// ===== rtl/bm25ts_if.sv =====
// Request and result channel interfaces of the BM25 term scorer.
interface bm25ts_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] docs_with_term;
  logic [31:0] doc_length;
  logic [31:0] term_freq;

  modport source (output valid, op, docs_with_term, doc_length, term_freq, input ready);
  modport sink   (input valid, op, docs_with_term, doc_length, term_freq, output ready);
endinterface

interface bm25ts_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] score;
  logic [1:0]  status;

  modport source (output valid, score, status, input ready);
  modport sink   (input valid, score, status, output ready);
endinterface

// ===== rtl/bm25ts_log_unit.sv =====
// Pipelined natural log of a ratio: normalise, divide, square, scale by ln 2.
module bm25ts_log_unit import bm25ts_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [LOG_W-1:0]     num,
  input  logic [LOG_W-1:0]     den,
  output logic [LOG_RES_W-1:0] ln_mag,
  output logic                 ln_neg
);

  function automatic logic [LOG_LEN_W-1:0] bit_len(input logic [LOG_W-1:0] x);
    logic [LOG_LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < LOG_W; i++) begin
      if (x[i]) n = LOG_LEN_W'(i + 1);
    end
    return n;
  endfunction

  // L1: bit lengths
  logic [LOG_W-1:0]     l1_p, l1_q;
  logic [LOG_LEN_W-1:0] l1_lp, l1_lq;
  // L2: normalised operands
  logic [LOG_W-1:0]     l2_pn, l2_qn;
  logic signed [6:0]    l2_e;

  // divider stages, index 0 is the L3 output
  logic [LOG_W:0]        dv_r  [0:LOG_MANT_W];
  logic [LOG_W-1:0]      dv_qn [0:LOG_MANT_W];
  logic [LOG_MANT_W-1:0] dv_m  [0:LOG_MANT_W];
  logic signed [6:0]     dv_e  [0:LOG_MANT_W];

  // squaring stages
  logic [LOG_MANT_W-1:0] sq_m [0:LOG_FRAC-1];
  logic [LOG_FRAC-1:0]   sq_f [0:LOG_FRAC-1];
  logic signed [6:0]     sq_e [0:LOG_FRAC-1];

  logic [LOG_W-1:0] f1_mag;
  logic             f1_neg;
  logic [46:0]      f2_hi;
  logic [45:0]      f2_lo;
  logic             f2_neg;
  logic [LOG_W-1:0] l2_raw;
  logic [63:0]      f3_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      l1_p  <= num;
      l1_q  <= den;
      l1_lp <= bit_len(num);
      l1_lq <= bit_len(den);
      l2_pn <= l1_p << (LOG_LEN_W'(LOG_W) - l1_lp);
      l2_qn <= l1_q << (LOG_LEN_W'(LOG_W) - l1_lq);
      l2_e  <= $signed({1'b0, l1_lp}) - $signed({1'b0, l1_lq});
      // keep the mantissa ratio in [1,2)
      if (l2_pn < l2_qn) begin
        dv_r[0] <= {l2_pn, 1'b0};
        dv_e[0] <= l2_e - 7'sd1;
      end else begin
        dv_r[0] <= {1'b0, l2_pn};
        dv_e[0] <= l2_e;
      end
      dv_qn[0] <= l2_qn;
      dv_m[0]  <= '0;
    end
  end

  for (genvar gi = 1; gi <= LOG_MANT_W; gi++) begin : g_div
    logic           ge;
    logic [LOG_W:0] diff;
    assign ge   = dv_r[gi-1] >= {1'b0, dv_qn[gi-1]};
    assign diff = ge ? (dv_r[gi-1] - {1'b0, dv_qn[gi-1]}) : dv_r[gi-1];
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[gi]  <= {diff[LOG_W-1:0], 1'b0};
        dv_qn[gi] <= dv_qn[gi-1];
        dv_m[gi]  <= {dv_m[gi-1][LOG_MANT_W-2:0], ge};
        dv_e[gi]  <= dv_e[gi-1];
      end
    end
  end

  for (genvar gj = 0; gj < LOG_FRAC; gj++) begin : g_sq
    logic [LOG_MANT_W-1:0]   m_in;
    logic [LOG_FRAC-1:0]     f_in;
    logic signed [6:0]       e_in;
    logic [2*LOG_MANT_W-1:0] sq;
    logic [LOG_MANT_W:0]     t;
    if (gj == 0) begin : g_first
      assign m_in = dv_m[LOG_MANT_W];
      assign f_in = '0;
      assign e_in = dv_e[LOG_MANT_W];
    end else begin : g_next
      assign m_in = sq_m[gj-1];
      assign f_in = sq_f[gj-1];
      assign e_in = sq_e[gj-1];
    end
    assign sq = m_in * m_in;
    assign t  = sq[LOG_FRAC +: LOG_MANT_W+1];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[gj] <= t[LOG_MANT_W] ? t[LOG_MANT_W:1] : t[LOG_MANT_W-1:0];
        sq_f[gj] <= {f_in[LOG_FRAC-2:0], t[LOG_MANT_W]};
        sq_e[gj] <= e_in;
      end
    end
  end

  // signed log2 in Q28 is exponent and fraction side by side
  assign l2_raw = {sq_e[LOG_FRAC-1], sq_f[LOG_FRAC-1]};
  assign f3_sum = (64'(f2_hi) << 17) + 64'(f2_lo) + (64'd1 << (56 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg <= l2_raw[LOG_W-1];
      f1_mag <= l2_raw[LOG_W-1] ? (~l2_raw + 1'b1) : l2_raw;
      f2_hi  <= f1_mag[LOG_W-1:17] * LN2_Q29;
      f2_lo  <= f1_mag[16:0] * LN2_Q29;
      f2_neg <= f1_neg;
      ln_mag <= f3_sum[57-FRAC_BITS +: LOG_RES_W];
      ln_neg <= f2_neg;
    end
  end

endmodule

// ===== rtl/bm25ts_bm25_unit.sv =====
// Pipelined classic BM25 saturation: length ratio divide, norm, score divide.
module bm25ts_bm25_unit import bm25ts_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       doc_length,
  input  logic [31:0]       term_freq,
  input  logic [31:0]       total_documents,
  input  logic [47:0]       coll_length,
  input  logic [15:0]       saturation_k,
  input  logic [16:0]       length_weight_b,
  output logic [31:0]       quotient,
  output bm25_flags_t       flags
);

  localparam int XSH = 16 + FRAC_BITS;

  logic [63:0]      c1_prod;
  logic [NUM_W-1:0] c1_num;
  logic [31:0]      c1_f;
  logic             c1_tz;

  // ratio divider, index 0 is the set-up stage
  logic [47:0]           d1_r    [0:RATIO_BITS];
  logic [RATIO_BITS-1:0] d1_bits [0:RATIO_BITS];
  logic [RATIO_BITS-1:0] d1_q    [0:RATIO_BITS];
  logic [NUM_W-1:0]      d1_num  [0:RATIO_BITS];
  logic [31:0]           d1_f    [0:RATIO_BITS];
  logic                  d1_tz   [0:RATIO_BITS];
  logic                  d1_ovf  [0:RATIO_BITS];

  logic [16:0]           b_eff;
  logic [RATIO_BITS-1:0] ratio;
  logic [39:0]           p1_hi, p1_lo;
  logic [NUM_W-1:0]      p1_num, p2_num, p3_num, p4_num;
  logic [31:0]           p1_f, p2_f, p3_f;
  logic                  p1_tz, p2_tz, p3_tz, p4_tz;
  logic [63:0]           norm_sum;
  logic [47:0]           p2_norm;
  logic [39:0]           p3_hi, p3_lo;
  logic [63:0]           p4_den;
  logic [96:0]           p4_x;

  // score divider, index 0 is the set-up stage
  logic [63:0]            d2_r    [0:QUOT_BITS];
  logic [QUOT_BITS-1:0]   d2_bits [0:QUOT_BITS];
  logic [QUOT_BITS-1:0]   d2_q    [0:QUOT_BITS];
  logic [63:0]            d2_den  [0:QUOT_BITS];
  logic                   d2_clamp[0:QUOT_BITS];
  logic                   d2_undef[0:QUOT_BITS];

  assign b_eff    = (length_weight_b > LEN_B_ONE) ? LEN_B_ONE : length_weight_b;
  assign ratio    = d1_ovf[RATIO_BITS] ? '1 : d1_q[RATIO_BITS];
  assign norm_sum = 64'({LEN_B_ONE - b_eff, 16'b0}) + (64'(p1_hi) << 23) + 64'(p1_lo);
  assign p4_x     = 97'(p4_num) << XSH;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_prod <= doc_length * total_documents;
      c1_num  <= term_freq * (17'(saturation_k) + 17'd4096);
      c1_f    <= term_freq;
      c1_tz   <= coll_length == '0;
      // quotient beyond the cap iff L*N*2^16 >= T*2^46
      d1_ovf[0]  <= {14'b0, c1_prod} >= {coll_length, 30'b0};
      d1_r[0]    <= 48'(c1_prod[63:30]);
      d1_bits[0] <= {c1_prod[29:0], 16'b0};
      d1_q[0]    <= '0;
      d1_num[0]  <= c1_num;
      d1_f[0]    <= c1_f;
      d1_tz[0]   <= c1_tz;
    end
  end

  for (genvar gi = 1; gi <= RATIO_BITS; gi++) begin : g_ratio
    logic [48:0] rr;
    logic        ge;
    assign rr = {d1_r[gi-1], d1_bits[gi-1][RATIO_BITS-1]};
    assign ge = rr >= {1'b0, coll_length};
    always_ff @(posedge clk) begin
      if (en) begin
        d1_r[gi]    <= ge ? 48'(rr - {1'b0, coll_length}) : rr[47:0];
        d1_bits[gi] <= {d1_bits[gi-1][RATIO_BITS-2:0], 1'b0};
        d1_q[gi]    <= {d1_q[gi-1][RATIO_BITS-2:0], ge};
        d1_num[gi]  <= d1_num[gi-1];
        d1_f[gi]    <= d1_f[gi-1];
        d1_tz[gi]   <= d1_tz[gi-1];
        d1_ovf[gi]  <= d1_ovf[gi-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hi   <= b_eff * ratio[RATIO_BITS-1:23];
      p1_lo   <= b_eff * ratio[22:0];
      p1_num  <= d1_num[RATIO_BITS];
      p1_f    <= d1_f[RATIO_BITS];
      p1_tz   <= d1_tz[RATIO_BITS];
      p2_norm <= norm_sum[63:16];
      p2_num  <= p1_num;
      p2_f    <= p1_f;
      p2_tz   <= p1_tz;
      p3_hi   <= saturation_k * p2_norm[47:24];
      p3_lo   <= saturation_k * p2_norm[23:0];
      p3_num  <= p2_num;
      p3_f    <= p2_f;
      p3_tz   <= p2_tz;
      p4_den  <= (64'(p3_f) << 28) + (64'(p3_hi) << 24) + 64'(p3_lo);
      p4_num  <= p3_num;
      p4_tz   <= p3_tz;
      // quotient beyond 32 bits iff num*2^XSH >= den*2^32
      d2_clamp[0] <= p4_x >= {1'b0, p4_den, 32'b0};
      d2_undef[0] <= p4_tz || (p4_den == '0);
      d2_r[0]     <= p4_x[95:32];
      d2_bits[0]  <= p4_x[31:0];
      d2_q[0]     <= '0;
      d2_den[0]   <= p4_den;
    end
  end

  for (genvar gk = 1; gk <= QUOT_BITS; gk++) begin : g_score
    logic [64:0] rr;
    logic        ge;
    assign rr = {d2_r[gk-1], d2_bits[gk-1][QUOT_BITS-1]};
    assign ge = rr >= {1'b0, d2_den[gk-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        d2_r[gk]     <= ge ? 64'(rr - {1'b0, d2_den[gk-1]}) : rr[63:0];
        d2_bits[gk]  <= {d2_bits[gk-1][QUOT_BITS-2:0], 1'b0};
        d2_q[gk]     <= {d2_q[gk-1][QUOT_BITS-2:0], ge};
        d2_den[gk]   <= d2_den[gk-1];
        d2_clamp[gk] <= d2_clamp[gk-1];
        d2_undef[gk] <= d2_undef[gk-1];
      end
    end
  end

  assign quotient    = d2_q[QUOT_BITS];
  assign flags.clamp = d2_clamp[QUOT_BITS];
  assign flags.undef = d2_undef[QUOT_BITS];

endmodule

// ===== rtl/bm25_term_scorer_core.sv =====
// Top level of the BM25 term scorer: request stage, units, result register.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    op, docs_with_term, doc_length, term_freq
//  rsp      out  valid/ready    score (Q16.16), status
//  cfg      in   cfg_wen        cfg_index, cfg_wdata (no read-back)
//
//  One request per cycle while the result register is free or being taken;
//  the two bit-per-stage dividers of the classic score unit set the longest
//  path. rst is synchronous and clears the valids and the config registers.
//  The whole pipeline moves only while the result register is free or being
//  taken, so a stall holds every stage and loses nothing.
module bm25_term_scorer_core import bm25ts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bm25ts_req_if.sink            req,
  bm25ts_rsp_if.source          rsp
);

  localparam logic [4:0] SP_BIAS = 5'(25 - FRAC_BITS);

  // configuration
  metric_t     cfg_metric;
  logic [15:0] cfg_k;
  logic [16:0] cfg_b;
  logic [31:0] cfg_n;
  logic [47:0] cfg_t;

  // pipeline advance: result register empty or draining
  logic adv;

  // request stage
  logic        s0_valid;
  logic        s0_op;
  logic [31:0] s0_n, s0_len, s0_f;

  side_t            side_next;
  logic [LOG_W-1:0] lg_p, lg_q;

  // side band line, aligned with the classic unit
  side_t               sb       [1:BM25_LAT];
  logic [BM25_LAT:1]   sb_valid;

  logic [LOG_RES_W-1:0] ln_mag;
  logic                 ln_neg;
  logic [LOG_RES_W-1:0] lp_mag [1:LOG_PAD];
  logic                 lp_neg [1:LOG_PAD];

  logic [31:0] bm_q;
  bm25_flags_t bm_flags;

  logic        res_score_next;
  logic [31:0] res_score;
  status_t     res_status;

  logic        out_valid;
  logic [31:0] out_score;
  status_t     out_status;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_metric <= METRIC_CLASSIC;
      cfg_k      <= SAT_K_RST;
      cfg_b      <= LEN_B_RST;
      cfg_n      <= '0;
      cfg_t      <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_METRIC: cfg_metric <= metric_t'(cfg_wdata[1:0]);
        REG_SAT_K:  cfg_k      <= cfg_wdata[15:0];
        REG_LEN_B:  cfg_b      <= cfg_wdata[16:0];
        REG_N_DOCS: cfg_n      <= cfg_wdata[31:0];
        REG_T_LEN:  cfg_t      <= cfg_wdata;
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op  <= req.op;
      s0_n   <= req.docs_with_term;
      s0_len <= req.doc_length;
      s0_f   <= req.term_freq;
    end
  end

  // Results that need no unit, and the log operands
  always_comb begin
    logic [4:0]  ex, ex_eff, rs;
    logic [9:0]  man;
    logic [10:0] sig;
    logic [63:0] wide;
    ex     = s0_f[14:10];
    man    = s0_f[9:0];
    ex_eff = (ex == 5'd0) ? 5'd1 : ex;
    sig    = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
    rs     = '0;
    wide   = '0;
    side_next.src    = SRC_DIRECT;
    side_next.score  = '0;
    side_next.status = ST_OK;

    if (s0_op == OP_DOC_SCORE) begin
      lg_p = LOG_W'(s0_f);
      lg_q = LOG_W'(1);
    end else if (cfg_metric == METRIC_CLASSIC) begin
      lg_p = LOG_W'({cfg_n, 1'b0}) + LOG_W'(2);
      lg_q = LOG_W'({s0_n, 1'b1});
    end else begin
      lg_p = LOG_W'(cfg_n) + LOG_W'(s0_n);
      lg_q = LOG_W'(s0_n);
    end

    if (s0_op == OP_TERM_WEIGHT) begin
      unique case (cfg_metric)
        METRIC_CLASSIC: side_next.src = SRC_LN_CLASSIC;
        METRIC_SPARSE:  side_next.score = 32'd1 << FRAC_BITS;
        default: begin
          if (s0_n == '0) side_next.status = ST_UNDEF;
          else            side_next.src    = SRC_LN_TF;
        end
      endcase
    end else begin
      unique case (cfg_metric)
        METRIC_CLASSIC: side_next.src = SRC_BM25;
        METRIC_TF_IDF: begin
          wide = {32'b0, s0_f} << FRAC_BITS;
        end
        METRIC_LOG_TF_IDF: begin
          if (s0_f == '0) side_next.status = ST_UNDEF;
          else            side_next.src    = SRC_LN_SCORE;
        end
        METRIC_SPARSE: begin
          // half float magnitude, sign ignored
          if (ex_eff >= SP_BIAS) begin
            wide = 64'(sig) << (ex_eff - SP_BIAS);
          end else begin
            rs   = SP_BIAS - ex_eff;
            wide = (64'(sig) + (64'd1 << (rs - 5'd1))) >> rs;
          end
        end
      endcase
      if (cfg_metric == METRIC_TF_IDF || cfg_metric == METRIC_SPARSE) begin
        if (cfg_metric == METRIC_SPARSE && ex == 5'd31) begin
          side_next.score  = (man != '0) ? 32'd0 : SCORE_MAX;
          side_next.status = (man != '0) ? ST_UNDEF : ST_SAT;
        end else if (wide[63:32] != '0) begin
          side_next.score  = SCORE_MAX;
          side_next.status = ST_SAT;
        end else begin
          side_next.score  = wide[31:0];
        end
      end
    end
  end

  bm25ts_log_unit u_log (
    .clk    (clk),
    .en     (adv),
    .num    (lg_p),
    .den    (lg_q),
    .ln_mag (ln_mag),
    .ln_neg (ln_neg)
  );

  bm25ts_bm25_unit u_bm25 (
    .clk             (clk),
    .en              (adv),
    .doc_length      (s0_len),
    .term_freq       (s0_f),
    .total_documents (cfg_n),
    .coll_length     (cfg_t),
    .saturation_k    (cfg_k),
    .length_weight_b (cfg_b),
    .quotient        (bm_q),
    .flags           (bm_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= '0;
    end else if (adv) begin
      sb_valid <= {sb_valid[BM25_LAT-1:1], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[1] <= side_next;
      for (int i = 2; i <= BM25_LAT; i++) sb[i] <= sb[i-1];
      // pad the shorter log path up to the classic unit
      lp_mag[1] <= ln_mag;
      lp_neg[1] <= ln_neg;
      for (int j = 2; j <= LOG_PAD; j++) begin
        lp_mag[j] <= lp_mag[j-1];
        lp_neg[j] <= lp_neg[j-1];
      end
    end
  end

  // Final selection
  always_comb begin
    res_score_next = 1'b0;
    res_score      = sb[BM25_LAT].score;
    res_status     = sb[BM25_LAT].status;
    unique case (sb[BM25_LAT].src)
      SRC_DIRECT: ;
      SRC_LN_CLASSIC: begin
        // weight below zero: clip to zero, flag unless it rounded away
        if (lp_neg[LOG_PAD]) begin
          res_score  = '0;
          res_status = (lp_mag[LOG_PAD] != '0) ? ST_SAT : ST_OK;
        end else begin
          res_score  = 32'(lp_mag[LOG_PAD]);
          res_status = ST_OK;
        end
      end
      SRC_LN_TF: begin
        res_score  = lp_neg[LOG_PAD] ? 32'd0 : 32'(lp_mag[LOG_PAD]);
        res_status = ST_OK;
      end
      SRC_LN_SCORE: begin
        res_score  = 32'(lp_mag[LOG_PAD]) + (32'd1 << FRAC_BITS);
        res_status = ST_OK;
      end
      SRC_BM25: begin
        res_score_next = 1'b1;
        if (bm_flags.undef) begin
          res_score  = '0;
          res_status = ST_UNDEF;
        end else if (bm_flags.clamp) begin
          res_score  = SCORE_MAX;
          res_status = ST_SAT;
        end else begin
          res_score  = bm_q;
          res_status = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sb_valid[BM25_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_score  <= res_score;
      out_status <= res_status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.score  = out_score;
  assign rsp.status = out_status;

`ifndef ASSERT_OFF
  // a held result must freeze the request side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while result stalled");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_UNDEF) |-> rsp.score == '0)
    else $error("undefined result with non-zero score");

  a_sat_bounds: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_SAT) |-> (rsp.score == '0 || rsp.score == SCORE_MAX))
    else $error("saturated result not at a bound");

  // classic score selection only ever comes from a classic unit slot
  a_bm25_slot: assert property (@(posedge clk) disable iff (rst)
    (adv && sb_valid[BM25_LAT] && res_score_next) |=> (rsp.valid && $past(cfg_metric) == METRIC_CLASSIC))
    else $error("classic score result outside classic metric");
`endif

endmodule
